[rtl/dtg_pkg.sv]
// Shared constants, types and the quarter-wave sine table of the decaying tone generator.
`default_nettype none
package dtg_pkg;

   // Sine table geometry.
   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int SINE_ENTRIES     = SINE_TABLE_DEPTH + 1;
   localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
   localparam int SINE_ADDR_W      = SINE_IDX_W + 1;
   localparam int MAG_W            = 15;

   // Field and register widths.
   localparam int STEP_W   = 32;
   localparam int PHASE_W  = 32;
   localparam int LEN_W    = 16;
   localparam int PEAK_W   = 15;
   localparam int POS_W    = 17;
   localparam int SAMPLE_W = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Serial arithmetic widths and step counts.
   localparam int MULT_W    = 16;
   localparam int MCAND_W   = 30;
   localparam int PROD_W    = MCAND_W + MULT_W;
   localparam int QUO_W     = 15;
   localparam int MUL_STEPS = MULT_W;
   localparam int DIV_STEPS = QUO_W;
   localparam int CNT_W     = 4;

   // Register reset values.
   localparam logic [LEN_W-1:0]  TONE_RESET = 16'd5512;
   localparam logic [LEN_W-1:0]  REST_RESET = 16'd16538;
   localparam logic [PEAK_W-1:0] PEAK_RESET = 15'd20000;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_TONE_SAMPLES   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REST_SAMPLES   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PEAK_AMPLITUDE = 2'd2;

   // Pi over two in Q30, the argument scale of the table series.
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_START,
      TOP_ARITH,
      TOP_OUT
   } top_state_type;

   typedef enum logic [1:0] {
      AR_IDLE,
      AR_MUL1,
      AR_MUL2,
      AR_DIV
   } arith_state_type;

   // Operands handed to the serial multiply and divide unit.
   typedef struct packed {
      logic [MAG_W-1:0]  mag;
      logic [PEAK_W-1:0] peak;
      logic [LEN_W-1:0]  diff;
      logic [LEN_W-1:0]  tone;
   } arith_req_type;

   typedef logic [SINE_ENTRIES-1:0][MAG_W-1:0] sine_rom_type;

   // Quarter sine by a fixed Q30 Taylor series, each term truncated, then scaled to Q15.
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type        rom;
      logic [63:0]         x;
      logic [63:0]         x2;
      logic [63:0]         term;
      logic [63:0]         v;
      logic signed [63:0]  sum;
      for (int k = 0; k < SINE_ENTRIES; k++) begin
         x    = (64'(k) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
         x2   = (x * x + (64'd1 << 29)) >> 30;
         sum  = signed'(x);
         term = ((x * x2) >> 30) / 64'd6;
         sum  = sum - signed'(term);
         term = ((term * x2) >> 30) / 64'd20;
         sum  = sum + signed'(term);
         term = ((term * x2) >> 30) / 64'd42;
         sum  = sum - signed'(term);
         term = ((term * x2) >> 30) / 64'd72;
         sum  = sum + signed'(term);
         term = ((term * x2) >> 30) / 64'd110;
         sum  = sum - signed'(term);
         term = ((term * x2) >> 30) / 64'd156;
         sum  = sum + signed'(term);
         if (sum < 0) begin
            sum = 0;
         end
         v = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
         if (v > 64'd32767) begin
            v = 64'd32767;
         end
         rom[k] = v[MAG_W-1:0];
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

endpackage
`default_nettype wire

[rtl/dtg_req_if.sv]
// Request channel carrying one phase step per sample tick.
`default_nettype none
interface dtg_req_if;
   logic                        valid;
   logic                        ready;
   logic [dtg_pkg::STEP_W-1:0]  phase_step;

   modport source (output valid, output phase_step, input ready);
   modport sink   (input valid, input phase_step, output ready);
endinterface
`default_nettype wire

[rtl/dtg_rsp_if.sv]
// Response channel carrying one audio sample and its period flags.
`default_nettype none
interface dtg_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [dtg_pkg::SAMPLE_W-1:0] sample;
   logic                                in_rest;
   logic                                period_end;

   modport source (output valid, output sample, output in_rest, output period_end,
                   input ready);
   modport sink   (input valid, input sample, input in_rest, input period_end,
                   output ready);
endinterface
`default_nettype wire

[rtl/dtg_mul_div.sv]
// Bit-serial unit computing floor(floor(mag*peak*diff / 2^15) / tone).
`default_nettype none
module dtg_mul_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire dtg_pkg::arith_req_type        operands,
   output logic                               done,
   output logic [dtg_pkg::QUO_W-1:0]          quotient
);

   dtg_pkg::arith_state_type         state_ff, state_in;
   logic [dtg_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic [dtg_pkg::PROD_W-1:0]       prod_ff, prod_in;
   logic [dtg_pkg::MCAND_W-1:0]      mcand_ff, mcand_in;
   logic                             done_ff, done_in;

   logic [dtg_pkg::MCAND_W:0]        mul_sum;
   logic [dtg_pkg::PROD_W-1:0]       mul_next;
   logic [dtg_pkg::LEN_W+1:0]        trial;
   logic [dtg_pkg::PROD_W-1:0]       div_next;

   // One multiplier bit per cycle: add the multiplicand into the upper half, shift right.
   assign mul_sum  = {1'b0, prod_ff[dtg_pkg::PROD_W-1:dtg_pkg::MULT_W]}
                   + (prod_ff[0] ? {1'b0, mcand_ff} : '0);
   assign mul_next = {mul_sum, prod_ff[dtg_pkg::MULT_W-1:1]};

   // One quotient bit per cycle: restoring division on the upper window, shifting left.
   assign trial    = {1'b0, prod_ff[45:29]} - {2'b00, operands.tone};
   assign div_next = trial[dtg_pkg::LEN_W+1] ? {prod_ff[44:0], 1'b0}
                                             : {trial[15:0], prod_ff[28:0], 1'b1};

   // Sequencer for the two multiplies and the divide.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      prod_in  = prod_ff;
      mcand_in = mcand_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         dtg_pkg::AR_IDLE: begin
            if (start) begin
               mcand_in = {{(dtg_pkg::MCAND_W-dtg_pkg::MAG_W){1'b0}}, operands.mag};
               prod_in  = {{(dtg_pkg::PROD_W-dtg_pkg::PEAK_W){1'b0}}, operands.peak};
               cnt_in   = '0;
               state_in = dtg_pkg::AR_MUL1;
            end
         end
         dtg_pkg::AR_MUL1: begin
            prod_in = mul_next;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == dtg_pkg::CNT_W'(dtg_pkg::MUL_STEPS - 1)) begin
               mcand_in = mul_next[dtg_pkg::MCAND_W-1:0];
               prod_in  = {{(dtg_pkg::PROD_W-dtg_pkg::LEN_W){1'b0}}, operands.diff};
               cnt_in   = '0;
               state_in = dtg_pkg::AR_MUL2;
            end
         end
         dtg_pkg::AR_MUL2: begin
            prod_in = mul_next;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == dtg_pkg::CNT_W'(dtg_pkg::MUL_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = dtg_pkg::AR_DIV;
            end
         end
         dtg_pkg::AR_DIV: begin
            prod_in = div_next;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == dtg_pkg::CNT_W'(dtg_pkg::DIV_STEPS - 1)) begin
               done_in  = 1'b1;
               state_in = dtg_pkg::AR_IDLE;
            end
         end
         default: state_in = dtg_pkg::AR_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dtg_pkg::AR_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      mcand_ff <= mcand_in;
   end

   assign done     = done_ff;
   assign quotient = prod_ff[dtg_pkg::QUO_W-1:0];

endmodule
`default_nettype wire

[rtl/decaying_tone_generator.sv]
// Top level: note period sequencing, phase accumulation, sine lookup and output register.
// A sounding beat reaches the output from acceptance via the start state, the bit-serial unit
// (16 + 16 multiply steps, 15 divide steps), its registered done and the output load state.
// A rest beat goes from acceptance straight to the output load state.
// The next beat enters once the previous one has reached the output register; a result held
// by the sink delays the following load by the cycles it is held.
// Synchronous active-high reset clears the sequencer, position, phase and latched step
// and loads the register defaults; no clearing pass is needed.
`default_nettype none
module decaying_tone_generator (
   input  wire logic                               clock,
   input  wire logic                               reset,
   dtg_req_if.sink                                 req_bus,
   dtg_rsp_if.source                               rsp_bus,
   input  wire logic                               csr_we,
   input  wire logic [dtg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [dtg_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   dtg_pkg::top_state_type              state_ff, state_in;

   logic [dtg_pkg::LEN_W-1:0]           tone_ff;
   logic [dtg_pkg::LEN_W-1:0]           rest_len_ff;
   logic [dtg_pkg::PEAK_W-1:0]          peak_ff;

   logic [dtg_pkg::POS_W-1:0]           pos_ff;
   logic [dtg_pkg::PHASE_W-1:0]         phase_ff;
   logic [dtg_pkg::STEP_W-1:0]          latched_ff;

   logic                                rest_ff;
   logic                                last_ff;
   logic                                neg_ff;
   logic [dtg_pkg::LEN_W-1:0]           diff_ff;
   logic [dtg_pkg::MAG_W-1:0]           mag_ff;

   logic                                rsp_valid_ff;
   logic [dtg_pkg::SAMPLE_W-1:0]        sample_ff, sample_in;
   logic                                in_rest_ff;
   logic                                period_end_ff;

   logic                                accept;
   logic                                pos_zero;
   logic [dtg_pkg::PHASE_W-1:0]         cur_phase;
   logic [dtg_pkg::STEP_W-1:0]          step_eff;
   logic [dtg_pkg::POS_W:0]             pos_plus;
   logic [dtg_pkg::POS_W-1:0]           period_len;
   logic                                last_now;
   logic                                rest_now;
   logic [dtg_pkg::SINE_IDX_W-1:0]      sine_idx;
   logic [dtg_pkg::SINE_ADDR_W-1:0]     rom_addr;
   logic                                out_free;
   logic                                out_load;
   logic                                arith_start;
   logic                                arith_done;
   logic [dtg_pkg::QUO_W-1:0]           arith_quo;
   dtg_pkg::arith_req_type              arith_ops;

   // Period bookkeeping for the beat on the request channel.
   assign accept     = req_bus.valid && req_bus.ready;
   assign pos_zero   = (pos_ff == '0);
   assign cur_phase  = pos_zero ? '0 : phase_ff;
   assign step_eff   = pos_zero ? req_bus.phase_step : latched_ff;
   assign pos_plus   = {1'b0, pos_ff} + 1'b1;
   assign period_len = {1'b0, tone_ff} + {1'b0, rest_len_ff};
   assign last_now   = (pos_plus >= {1'b0, period_len});
   assign rest_now   = (pos_ff >= {1'b0, tone_ff});

   // Quadrant folding of the phase into a quarter-wave table address.
   assign sine_idx = cur_phase[dtg_pkg::PHASE_W-3 -: dtg_pkg::SINE_IDX_W];
   assign rom_addr = cur_phase[dtg_pkg::PHASE_W-2]
                   ? dtg_pkg::SINE_ADDR_W'(dtg_pkg::SINE_TABLE_DEPTH) - {1'b0, sine_idx}
                   : {1'b0, sine_idx};

   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // Beat sequencer.
   always_comb begin
      state_in    = state_ff;
      arith_start = 1'b0;
      out_load    = 1'b0;
      unique case (state_ff)
         dtg_pkg::TOP_IDLE: begin
            if (accept) begin
               state_in = rest_now ? dtg_pkg::TOP_OUT : dtg_pkg::TOP_START;
            end
         end
         dtg_pkg::TOP_START: begin
            arith_start = 1'b1;
            state_in    = dtg_pkg::TOP_ARITH;
         end
         dtg_pkg::TOP_ARITH: begin
            if (arith_done) begin
               state_in = dtg_pkg::TOP_OUT;
            end
         end
         dtg_pkg::TOP_OUT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = dtg_pkg::TOP_IDLE;
            end
         end
         default: state_in = dtg_pkg::TOP_IDLE;
      endcase
   end

   assign req_bus.ready = (state_ff == dtg_pkg::TOP_IDLE) && !reset;

   // Sequencer state and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dtg_pkg::TOP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Configuration registers; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         tone_ff     <= dtg_pkg::TONE_RESET;
         rest_len_ff <= dtg_pkg::REST_RESET;
         peak_ff     <= dtg_pkg::PEAK_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            dtg_pkg::CSR_TONE_SAMPLES:   tone_ff     <= csr_wdata;
            dtg_pkg::CSR_REST_SAMPLES:   rest_len_ff <= csr_wdata;
            dtg_pkg::CSR_PEAK_AMPLITUDE: peak_ff     <= csr_wdata[dtg_pkg::PEAK_W-1:0];
            default: ;
         endcase
      end
   end

   // Position, phase accumulator and latched step advance on every accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         phase_ff   <= '0;
         latched_ff <= '0;
      end else if (accept) begin
         pos_ff     <= last_now ? '0 : pos_plus[dtg_pkg::POS_W-1:0];
         phase_ff   <= cur_phase + step_eff;
         latched_ff <= step_eff;
      end
   end

   // Per-beat operands and registered table read.
   always_ff @(posedge clock) begin
      if (accept) begin
         rest_ff <= rest_now;
         last_ff <= last_now;
         neg_ff  <= cur_phase[dtg_pkg::PHASE_W-1];
         diff_ff <= tone_ff - pos_ff[dtg_pkg::LEN_W-1:0];
         mag_ff  <= dtg_pkg::SINE_ROM[rom_addr];
      end
   end

   assign arith_ops.mag  = mag_ff;
   assign arith_ops.peak = peak_ff;
   assign arith_ops.diff = diff_ff;
   assign arith_ops.tone = tone_ff;

   dtg_mul_div u_mul_div (
      .clock    (clock),
      .reset    (reset),
      .start    (arith_start),
      .operands (arith_ops),
      .done     (arith_done),
      .quotient (arith_quo)
   );

   // Signed sample from the scaled magnitude; rest samples are zero.
   always_comb begin
      if (rest_ff) begin
         sample_in = '0;
      end else if (neg_ff) begin
         sample_in = dtg_pkg::SAMPLE_W'(0) - {1'b0, arith_quo};
      end else begin
         sample_in = {1'b0, arith_quo};
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (out_load) begin
         sample_ff     <= sample_in;
         in_rest_ff    <= rest_ff;
         period_end_ff <= last_ff;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.sample     = sample_ff;
   assign rsp_bus.in_rest    = in_rest_ff;
   assign rsp_bus.period_end = period_end_ff;

   // The arithmetic unit only finishes while the sequencer waits for it.
   a_done_in_arith: assert property (@(posedge clock) disable iff (reset)
      arith_done |-> (state_ff == dtg_pkg::TOP_ARITH))
      else $error("arithmetic result arrived outside the wait state");

   // A beat at the start of a period latches its own phase step.
   a_step_latched: assert property (@(posedge clock) disable iff (reset)
      (accept && pos_zero) |=> (latched_ff == $past(req_bus.phase_step)))
      else $error("phase step not latched at period start");

   // A sounding beat goes to the arithmetic unit, a rest beat straight to the output.
   a_beat_route: assert property (@(posedge clock) disable iff (reset)
      accept |=> ((state_ff == dtg_pkg::TOP_START) != $past(rest_now)))
      else $error("beat routed the wrong way after acceptance");

endmodule
`default_nettype wire
